// ===== hw/rtl/dtb_pkg.sv =====
// Shared types, command codes and arithmetic helpers for the decimating trail buffer.
`timescale 1ns / 1ps

package dtb_pkg;

    localparam int CMD_W   = 2;
    localparam int COORD_W = 32;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord z;
        t_coord y;
        t_coord x;
    } t_pos;

    localparam int POS_W = $bits(t_pos);

    // Controller to datapath
    typedef struct packed {
        logic cap;          // take the accepted item's payload
        logic push_now;     // append input position at the fill count
        logic clear;        // empty the trail
        logic rd_issue;     // read the entry at rd_index
        logic halve_begin;  // arm the halving pass
        logic halve_rd;     // issue the next read of the halving pass
        logic push_halved;  // append the held position after halving
        logic load_out;     // load the result register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic halve_last;
        logic out_free;
    } t_dp_sts;

    // Floor of (a + b) / 2, exact in 33 bits
    function automatic t_coord floor_avg(input t_coord a, input t_coord b);
        logic signed [COORD_W:0] sum;
        sum = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        return sum[COORD_W:1];
    endfunction

    function automatic t_pos pos_avg(input t_pos a, input t_pos b);
        t_pos r;
        r.x = floor_avg(a.x, b.x);
        r.y = floor_avg(a.y, b.y);
        r.z = floor_avg(a.z, b.z);
        return r;
    endfunction

endpackage

// ===== hw/rtl/dtb_cmd_if.sv =====
// Command channel: valid/ready with command, position and read index.
`timescale 1ns / 1ps

interface dtb_cmd_if #(
    parameter int IDX_W = 10
);
    logic                      valid;
    logic                      ready;
    logic [dtb_pkg::CMD_W-1:0] cmd;
    dtb_pkg::t_coord           pos_x;
    dtb_pkg::t_coord           pos_y;
    dtb_pkg::t_coord           pos_z;
    logic [IDX_W-1:0]          rd_index;

    modport source (output valid, cmd, pos_x, pos_y, pos_z, rd_index, input ready);
    modport sink   (input valid, cmd, pos_x, pos_y, pos_z, rd_index, output ready);
endinterface

// ===== hw/rtl/dtb_res_if.sv =====
// Result channel: valid/ready with count, read flag and read position.
`timescale 1ns / 1ps

interface dtb_res_if #(
    parameter int CNT_W = 11
);
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] count;
    logic             rd_valid;
    dtb_pkg::t_coord  out_x;
    dtb_pkg::t_coord  out_y;
    dtb_pkg::t_coord  out_z;

    modport source (output valid, count, rd_valid, out_x, out_y, out_z, input ready);
    modport sink   (input valid, count, rd_valid, out_x, out_y, out_z, output ready);
endinterface

// ===== hw/rtl/dtb_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps

module dtb_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/dtb_ctrl.sv =====
// Sequencer: accepts commands, runs the halving pass, hands results to the output.
`timescale 1ns / 1ps

module dtb_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [dtb_pkg::CMD_W-1:0] i_cmd,
    output logic                      o_ready,
    input  dtb_pkg::t_dp_sts          i_sts,
    output dtb_pkg::t_dp_cmd          o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HALVE = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_HPUSH = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_RESP;
                    case (i_cmd)
                        dtb_pkg::CMD_PUSH: begin
                            if (i_sts.full) begin
                                o_cmd.halve_begin = 1'b1;
                                n_state           = S_HALVE;
                            end else begin
                                o_cmd.push_now = 1'b1;
                            end
                        end
                        dtb_pkg::CMD_CLEAR: o_cmd.clear    = 1'b1;
                        dtb_pkg::CMD_READ:  o_cmd.rd_issue = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_HALVE: begin
                o_cmd.halve_rd = 1'b1;
                if (i_sts.halve_last) begin
                    n_state = S_DRAIN;
                end
            end
            // last pair is averaged and written here
            S_DRAIN: n_state = S_HPUSH;
            S_HPUSH: begin
                o_cmd.push_halved = 1'b1;
                n_state           = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== hw/rtl/dtb_datapath.sv =====
// Trail store, fill count, halving pipeline and result register.
`timescale 1ns / 1ps

module dtb_datapath #(
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = AW + 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dtb_pkg::t_dp_cmd   i_cmd,
    output dtb_pkg::t_dp_sts   o_sts,
    input  dtb_pkg::t_coord    i_pos_x,
    input  dtb_pkg::t_coord    i_pos_y,
    input  dtb_pkg::t_coord    i_pos_z,
    input  logic [AW-1:0]      i_rd_index,
    dtb_res_if.source          o_res
);
    localparam logic [CW-1:0] CNT_FULL  = CW'(DEPTH);
    localparam logic [CW-1:0] CNT_AFTER = CW'(DEPTH / 2 + 1);
    localparam logic [AW-1:0] HALF_ADDR = AW'(DEPTH / 2);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [AW-1:0] FIRST_RD  = AW'(2);

    logic [CW-1:0]     r_cnt;
    logic [AW-1:0]     r_ptr;
    logic              r_lag_v;
    logic [AW-1:0]     r_lag_a;
    dtb_pkg::t_pos     r_even;
    dtb_pkg::t_pos     r_hold;
    logic              r_rd_ok;
    logic              r_out_v;
    logic [CW-1:0]     r_o_count;
    logic              r_o_rd_valid;
    dtb_pkg::t_pos     r_o_pos;

    dtb_pkg::t_pos     in_pos;
    dtb_pkg::t_pos     rdata;
    logic              lag_odd;
    logic              we;
    logic [AW-1:0]     waddr;
    dtb_pkg::t_pos     wdata;
    logic              re;
    logic [AW-1:0]     raddr;
    logic              rd_in_range;

    assign in_pos      = '{z: i_pos_z, y: i_pos_y, x: i_pos_x};
    assign rd_in_range = {1'b0, i_rd_index} < r_cnt;

    // data of the odd address lands now: average with the held even one
    assign lag_odd = r_lag_v && r_lag_a[0];

    always_comb begin
        we    = i_cmd.push_now || i_cmd.push_halved || lag_odd;
        waddr = r_cnt[AW-1:0];
        wdata = in_pos;
        if (lag_odd) begin
            waddr = {1'b0, r_lag_a[AW-1:1]};
            wdata = dtb_pkg::pos_avg(r_even, rdata);
        end else if (i_cmd.push_halved) begin
            waddr = HALF_ADDR;
            wdata = r_hold;
        end
    end

    assign re    = i_cmd.rd_issue || i_cmd.halve_rd;
    assign raddr = i_cmd.halve_rd ? r_ptr : i_rd_index;

    dtb_ram #(
        .WIDTH (dtb_pkg::POS_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_lag_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_cnt <= '0;
            end else if (i_cmd.push_now) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.push_halved) begin
                r_cnt <= CNT_AFTER;
            end
            r_lag_v <= i_cmd.halve_rd;
            if (i_cmd.load_out) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.halve_begin) begin
            r_ptr <= FIRST_RD;
        end else if (i_cmd.halve_rd) begin
            r_ptr <= r_ptr + AW'(1);
        end
        r_lag_a <= r_ptr;
        if (r_lag_v && !r_lag_a[0]) begin
            r_even <= rdata;
        end
        if (i_cmd.cap) begin
            r_hold  <= in_pos;
            r_rd_ok <= i_cmd.rd_issue && rd_in_range;
        end
        if (i_cmd.load_out) begin
            r_o_count    <= r_cnt;
            r_o_rd_valid <= r_rd_ok;
            r_o_pos      <= r_rd_ok ? rdata : '0;
        end
    end

    assign o_sts.full       = r_cnt == CNT_FULL;
    assign o_sts.halve_last = r_ptr == LAST_ADDR;
    assign o_sts.out_free   = !r_out_v || o_res.ready;

    assign o_res.valid    = r_out_v;
    assign o_res.count    = r_o_count;
    assign o_res.rd_valid = r_o_rd_valid;
    assign o_res.out_x    = r_o_pos.x;
    assign o_res.out_y    = r_o_pos.y;
    assign o_res.out_z    = r_o_pos.z;
endmodule

// ===== hw/rtl/decimating_trail_buffer.sv =====
// A push, clear or read is accepted in S_IDLE; the sequencer then moves to S_RESP,
// which loads the result register once the output register is free or being taken.
// A push into a full store runs a halving pass first, through S_HALVE, S_DRAIN and S_HPUSH,
// on the single store read port (one entry per cycle, DEPTH - 2 reads), before S_RESP.
// A new command is taken as soon as the previous result sits in the output register.
`timescale 1ns / 1ps

module decimating_trail_buffer #(
    parameter int DEPTH = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dtb_cmd_if.sink   i_cmd,
    dtb_res_if.source o_res
);
    // Reset: synchronous, active low; clears the fill count, sequencer and output valid.
    dtb_pkg::t_dp_cmd dp_cmd;
    dtb_pkg::t_dp_sts dp_sts;
    logic             ready;

    assign i_cmd.ready = ready;

    dtb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.valid),
        .i_cmd   (i_cmd.cmd),
        .o_ready (ready),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    dtb_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .i_pos_x    (i_cmd.pos_x),
        .i_pos_y    (i_cmd.pos_y),
        .i_pos_z    (i_cmd.pos_z),
        .i_rd_index (i_cmd.rd_index),
        .o_res      (o_res)
    );
endmodule
